### sv/owbm_pkg.sv
`timescale 1ns / 1ps
// Shared types, register indexes and the CRC-8 helper of the 1-wire bus master.
// Has no dependencies; every other file of the block imports it.
package owbm_pkg;

  localparam int unsigned NUM_REGS = 7;
  localparam int unsigned REG_BITS = 10;

  localparam logic [2:0] REG_RESET_LOW      = 3'd0;
  localparam logic [2:0] REG_PRESENCE_SAMPLE = 3'd1;
  localparam logic [2:0] REG_RESET_TAIL     = 3'd2;
  localparam logic [2:0] REG_SHORT_LOW      = 3'd3;
  localparam logic [2:0] REG_LONG_LOW       = 3'd4;
  localparam logic [2:0] REG_READ_SAMPLE    = 3'd5;
  localparam logic [2:0] REG_SLOT           = 3'd6;

  localparam logic [REG_BITS-1:0] RESET_LOW_INIT       = 10'd480;
  localparam logic [REG_BITS-1:0] PRESENCE_SAMPLE_INIT = 10'd70;
  localparam logic [REG_BITS-1:0] RESET_TAIL_INIT      = 10'd410;
  localparam logic [REG_BITS-1:0] SHORT_LOW_INIT       = 10'd6;
  localparam logic [REG_BITS-1:0] LONG_LOW_INIT        = 10'd60;
  localparam logic [REG_BITS-1:0] READ_SAMPLE_INIT     = 10'd9;
  localparam logic [REG_BITS-1:0] SLOT_INIT            = 10'd70;

  localparam logic [7:0] CRC_POLY = 8'h8C;

  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_RESET = 3'd1;
  localparam logic [2:0] KIND_WRITE = 3'd2;
  localparam logic [2:0] KIND_READ  = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_RESET = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_CLEAR = 3'd4,
    OP_NONE  = 3'd5
  } op_t;

  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_RST_LOW  = 6'b000010,
    PH_RST_WAIT = 6'b000100,
    PH_RST_TAIL = 6'b001000,
    PH_WRITE    = 6'b010000,
    PH_READ     = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_byte;
    logic [7:0] crc_value;
    logic       crc_zero;
  } out_item_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic       line_level;
  } cmd_t;

  typedef struct packed {
    logic [REG_BITS-1:0] reset_low_ticks;
    logic [REG_BITS-1:0] presence_sample_ticks;
    logic [REG_BITS-1:0] reset_tail_ticks;
    logic [REG_BITS-1:0] short_low_ticks;
    logic [REG_BITS-1:0] long_low_ticks;
    logic [REG_BITS-1:0] read_sample_ticks;
    logic [REG_BITS-1:0] slot_ticks;
  } cfg_regs_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic [7:0] d;
    logic       mix;
    crc = crc_in;
    d   = data;
    for (int k = 0; k < 8; k++) begin
      mix = crc[0] ^ d[0];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CRC_POLY;
      end
      d = d >> 1;
    end
    return crc;
  endfunction

endpackage

### sv/owbm_front.sv
`timescale 1ns / 1ps
// Front end: accepts input items and classifies them into queue commands.
// Depends on owbm_pkg.
module owbm_front (
  input  logic                     in_valid,
  output logic                     in_stall,
  input  owbm_pkg::in_item_t       in_item,
  input  owbm_pkg::queue_status_t  q_status,
  output logic                     push,
  output owbm_pkg::cmd_t           push_cmd
);
  import owbm_pkg::*;

  op_t op;

  always_comb begin
    unique case (in_item.kind)
      KIND_TICK:  op = OP_TICK;
      KIND_RESET: op = OP_RESET;
      KIND_WRITE: op = OP_WRITE;
      KIND_READ:  op = OP_READ;
      KIND_CLEAR: op = OP_CLEAR;
      default:    op = OP_NONE;
    endcase
  end

  assign in_stall            = q_status.full;
  assign push                = in_valid && !q_status.full;
  assign push_cmd.op         = op;
  assign push_cmd.data_byte  = in_item.data_byte;
  assign push_cmd.line_level = in_item.line_level;

endmodule

### sv/owbm_queue.sv
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the bus sequencer.
// Depends on owbm_pkg.
module owbm_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  owbm_pkg::cmd_t           push_cmd,
  input  logic                     pop,
  output owbm_pkg::cmd_t           head,
  output owbm_pkg::queue_status_t  status
);
  import owbm_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  assign head         = entries[rd_ptr];
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

  assert property (@(posedge clk) disable iff (rst) status.full |-> !push)
    else $error("queue written while full");
  assert property (@(posedge clk) disable iff (rst) status.empty |-> !pop)
    else $error("queue read while empty");
  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");

endmodule

### sv/owbm_back.sv
`timescale 1ns / 1ps
// Bus sequencer: runs reset, write and read slots one command per cycle
// unless stalled, and registers the result item. Depends on owbm_pkg.
module owbm_back #(
  parameter int TICK_COUNT_BITS = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  owbm_pkg::cfg_regs_t      cfg,
  input  owbm_pkg::cmd_t           head,
  input  owbm_pkg::queue_status_t  q_status,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output owbm_pkg::out_item_t      out_item
);
  import owbm_pkg::*;

  localparam int CW = (TICK_COUNT_BITS > 11) ? TICK_COUNT_BITS : 11;
  localparam logic [TICK_COUNT_BITS-1:0] CNT_MAX = {TICK_COUNT_BITS{1'b1}};

  phase_t                     phase, phase_next;
  logic [TICK_COUNT_BITS-1:0] tick_count, tick_count_next, cnt_inc;
  logic [2:0]                 bit_index, bit_index_next;
  logic [7:0]                 shift_byte, shift_byte_next;
  logic [7:0]                 crc_accum, crc_accum_next;
  logic                       presence_flag, presence_flag_next;
  logic [7:0]                 last_read, last_read_next;
  logic                       done, drive;
  logic [CW-1:0]              cnt_ext, slot_len, sample_sum, sample_pt, low_len;
  logic                       slot_end, sample_now;

  function automatic logic reached(input logic [CW-1:0] cnt, input logic [REG_BITS-1:0] len,
                                   input logic at_max);
    logic [CW-1:0] l;
    l = (len == '0) ? CW'(1) : CW'(len);
    return (cnt >= l) || at_max;
  endfunction

  assign pop     = !q_status.empty && (!out_valid || !out_stall);
  assign cnt_inc = (tick_count == CNT_MAX) ? tick_count : tick_count + 1'b1;
  assign cnt_ext = CW'(cnt_inc);

  assign slot_len   = (cfg.slot_ticks == '0) ? CW'(1) : CW'(cfg.slot_ticks);
  assign sample_sum = CW'(cfg.short_low_ticks) + CW'(cfg.read_sample_ticks);
  assign sample_pt  = (sample_sum > slot_len) ? slot_len :
                      ((sample_sum == '0) ? CW'(1) : sample_sum);
  assign slot_end   = reached(cnt_ext, cfg.slot_ticks, cnt_inc == CNT_MAX);
  assign sample_now = (cnt_ext == sample_pt) || (slot_end && (cnt_ext < sample_pt));

  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    crc_accum_next     = crc_accum;
    presence_flag_next = presence_flag;
    last_read_next     = last_read;
    done               = 1'b0;
    if (phase == PH_IDLE) begin
      case (head.op)
        OP_RESET: begin
          phase_next         = PH_RST_LOW;
          tick_count_next    = '0;
          presence_flag_next = 1'b0;
          crc_accum_next     = '0;
        end
        OP_WRITE: begin
          phase_next      = PH_WRITE;
          tick_count_next = '0;
          bit_index_next  = '0;
          shift_byte_next = head.data_byte;
        end
        OP_READ: begin
          phase_next      = PH_READ;
          tick_count_next = '0;
          bit_index_next  = '0;
          shift_byte_next = '0;
        end
        OP_CLEAR: crc_accum_next = '0;
        default: ;
      endcase
    end else if (head.op == OP_TICK) begin
      tick_count_next = cnt_inc;
      unique case (phase)
        PH_RST_LOW: begin
          if (reached(cnt_ext, cfg.reset_low_ticks, cnt_inc == CNT_MAX)) begin
            phase_next      = PH_RST_WAIT;
            tick_count_next = '0;
          end
        end
        PH_RST_WAIT: begin
          if (reached(cnt_ext, cfg.presence_sample_ticks, cnt_inc == CNT_MAX)) begin
            presence_flag_next = !head.line_level;
            phase_next         = PH_RST_TAIL;
            tick_count_next    = '0;
          end
        end
        PH_RST_TAIL: begin
          if (reached(cnt_ext, cfg.reset_tail_ticks, cnt_inc == CNT_MAX)) begin
            phase_next      = PH_IDLE;
            tick_count_next = '0;
            done            = 1'b1;
          end
        end
        default: begin
          if (phase == PH_READ && sample_now) begin
            shift_byte_next = {head.line_level, shift_byte[7:1]};
          end
          if (slot_end) begin
            if (phase == PH_WRITE) begin
              shift_byte_next = shift_byte >> 1;
            end
            bit_index_next  = bit_index + 3'd1;
            tick_count_next = '0;
            if (bit_index_next == 3'd0) begin
              if (phase == PH_READ) begin
                last_read_next = shift_byte_next;
                crc_accum_next = crc8_byte(crc_accum, shift_byte_next);
              end
              phase_next = PH_IDLE;
              done       = 1'b1;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    low_len = '0;
    if (phase_next == PH_WRITE) begin
      low_len = shift_byte_next[0] ? CW'(cfg.short_low_ticks) : CW'(cfg.long_low_ticks);
    end else if (phase_next == PH_READ) begin
      low_len = CW'(cfg.short_low_ticks);
    end
    drive = (phase_next == PH_RST_LOW) || (CW'(tick_count_next) < low_len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      crc_accum     <= '0;
      presence_flag <= 1'b0;
      last_read     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        phase         <= phase_next;
        tick_count    <= tick_count_next;
        bit_index     <= bit_index_next;
        shift_byte    <= shift_byte_next;
        crc_accum     <= crc_accum_next;
        presence_flag <= presence_flag_next;
        last_read     <= last_read_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item.drive_low <= drive;
      out_item.busy_res  <= (phase_next != PH_IDLE);
      out_item.done_res  <= done;
      out_item.presence  <= presence_flag_next;
      out_item.read_byte <= last_read_next;
      out_item.crc_value <= crc_accum_next;
      out_item.crc_zero  <= (crc_accum_next == 8'd0);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.done_res |-> !out_item.busy_res)
    else $error("done reported while still busy");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.drive_low |-> out_item.busy_res)
    else $error("bus driven low while idle");
  assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> tick_count == '0)
    else $error("tick counter not cleared in idle");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("held result changed under stall");

endmodule

### sv/one_wire_bus_master.sv
`timescale 1ns / 1ps
// Top level of the 1-wire bus master with CRC-8 over received bytes.
// Depends on owbm_pkg, owbm_front, owbm_queue and owbm_back.
//
// Each input item is one microsecond tick or one command, and each gives
// exactly one result item. An input item is taken every clock cycle while the
// two-entry command queue has room, and the sequencer retires one item per
// cycle while the result register is free or being taken, so the sustained
// rate is one item per clock. An item's result is presented once the item
// has passed through the command queue and the result register, and it
// can be taken at the following edge. Configuration registers may be written
// whenever no accepted item is still waiting for its result; cfg_ready is
// always high and writes to indexes past the last register are dropped.
module one_wire_bus_master #(
  parameter int TICK_COUNT_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  owbm_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output owbm_pkg::out_item_t                  out_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [2:0]                           cfg_index,
  input  logic [owbm_pkg::REG_BITS-1:0]        cfg_data
);
  import owbm_pkg::*;

  cfg_regs_t     cfg;
  cmd_t          push_cmd, head;
  logic          push, pop;
  queue_status_t q_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks       <= RESET_LOW_INIT;
      cfg.presence_sample_ticks <= PRESENCE_SAMPLE_INIT;
      cfg.reset_tail_ticks      <= RESET_TAIL_INIT;
      cfg.short_low_ticks       <= SHORT_LOW_INIT;
      cfg.long_low_ticks        <= LONG_LOW_INIT;
      cfg.read_sample_ticks     <= READ_SAMPLE_INIT;
      cfg.slot_ticks            <= SLOT_INIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RESET_LOW:       cfg.reset_low_ticks       <= cfg_data;
        REG_PRESENCE_SAMPLE: cfg.presence_sample_ticks <= cfg_data;
        REG_RESET_TAIL:      cfg.reset_tail_ticks      <= cfg_data;
        REG_SHORT_LOW:       cfg.short_low_ticks       <= cfg_data;
        REG_LONG_LOW:        cfg.long_low_ticks        <= cfg_data;
        REG_READ_SAMPLE:     cfg.read_sample_ticks     <= cfg_data;
        REG_SLOT:            cfg.slot_ticks            <= cfg_data;
        default: ;
      endcase
    end
  end

  owbm_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  owbm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  owbm_back #(
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
